### rtl/lbga_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the line balance greedy assigner
// no dependencies

package lbga_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EDGE = 2'd1,
    ACT_RUN  = 2'd2
  } action_t;

  typedef enum logic {
    CFG_CYCLE_TIME = 1'b0,
    CFG_TASK_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_ROW,
    ST_DEC
  } state_t;

  typedef struct packed {
    logic [15:0] duration;
    logic [23:0] priority_val;
    logic [5:0]  preds;
  } task_entry_t;

  localparam int TASK_ENTRY_W = $bits(task_entry_t);

endpackage

### rtl/lbga_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module lbga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/line_balance_greedy_assigner_core.sv
`timescale 1ns / 1ps
// greedy station-oriented line balancing assigner, top level
// depends on lbga_pkg and lbga_ram

// A load transaction writes its task entry when taken and an edge transaction
// reads, then writes back, the successor row. A run over n tasks first copies
// the predecessor counts; each selection then scans the task and count
// memories one entry per cycle, and each assigned task sweeps the count
// memory once more to decrement its successors, while each station change
// costs one scan. Every pass is a serial sweep, set by the single read port of
// the memories. Results leave through an output register; the next selection
// waits only until that register is free. Loaded data persist across runs.
module line_balance_greedy_assigner_core #(
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [6:0]  task_id,
  input  logic [15:0] duration,
  input  logic [5:0]  pending_preds,
  input  logic [23:0] priority_req,
  input  logic [6:0]  successor_id,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [6:0]  task_id_res,
  output logic [6:0]  station,
  output logic        last,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import lbga_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [6:0] MAX7 = 7'(MAX_TASKS);

  state_t state, state_next;

  logic [15:0] cycle_time;
  logic [6:0]  task_count;

  logic [CW-1:0] n_tasks;
  logic [CW-1:0] cnt;
  logic          p_valid;
  logic [IW-1:0] p_addr;
  logic          issue;

  logic [MAX_TASKS-1:0] assigned;
  logic [MAX_TASKS-1:0] row_valid;
  logic [MAX_TASKS-1:0] row;
  logic [15:0]   free_time;
  logic [6:0]    cur_station;
  logic [CW-1:0] total;
  logic          station_used;

  logic          found;
  logic [IW-1:0] best;
  logic [23:0]   best_pri;
  logic [15:0]   best_dur;

  logic [IW-1:0] edge_src;
  logic [IW-1:0] edge_dst;

  // task memory
  logic          task_we;
  logic [IW-1:0] task_waddr;
  task_entry_t   task_wdata, task_rd;
  logic [TASK_ENTRY_W-1:0] task_rdata;

  // successor rows
  logic                 succ_we;
  logic [IW-1:0]        succ_waddr, succ_raddr;
  logic [MAX_TASKS-1:0] succ_wdata, succ_rdata;

  // working predecessor counts
  logic          work_we;
  logic [IW-1:0] work_waddr;
  logic [6:0]    work_wdata, work_rdata;

  logic accept, tid_ok, sid_ok, out_free, cand, res_load;

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign tid_ok     = (task_id >= 7'd1) && (task_id <= MAX7);
  assign sid_ok     = (successor_id >= 7'd1) && (successor_id <= MAX7);
  assign out_free   = !res_valid || res_ready;
  assign issue      = (cnt < n_tasks);
  assign task_rd    = task_entry_t'(task_rdata);
  assign res_load   = (state == ST_PICK) && out_free && (found || !station_used);

  assign cand = p_valid && !assigned[p_addr] && (work_rdata == 7'd0) &&
                (task_rd.duration <= free_time);

  lbga_ram #(.WIDTH(TASK_ENTRY_W), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (task_rdata)
  );

  lbga_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_succ_ram (
    .clk   (clk),
    .we    (succ_we),
    .waddr (succ_waddr),
    .wdata (succ_wdata),
    .raddr (succ_raddr),
    .rdata (succ_rdata)
  );

  lbga_ram #(.WIDTH(7), .DEPTH(MAX_TASKS)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (work_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_EDGE && tid_ok && sid_ok) begin
            state_next = ST_EDGE;
          end else if (action == ACT_RUN) begin
            state_next = ST_INIT;
          end
        end
      end
      ST_EDGE: state_next = ST_IDLE;
      ST_INIT: begin
        if (!issue && !p_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !p_valid) state_next = ST_PICK;
      end
      ST_PICK: begin
        if (found) begin
          if (out_free) begin
            state_next = ((total + 1'b1) == n_tasks) ? ST_IDLE : ST_ROW;
          end
        end else if (!station_used) begin
          if (out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_ROW: state_next = ST_DEC;
      ST_DEC: begin
        if (!issue && !p_valid) state_next = ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    task_we    = (state == ST_IDLE) && accept && (action == ACT_LOAD) && tid_ok;
    task_waddr = IW'(task_id - 7'd1);
    task_wdata = '{duration: duration, priority_val: priority_req, preds: pending_preds};

    succ_raddr = (state == ST_IDLE) ? IW'(task_id - 7'd1) : best;
    succ_we    = (state == ST_EDGE);
    succ_waddr = edge_src;
    succ_wdata = (row_valid[edge_src] ? succ_rdata : '0) |
                 (MAX_TASKS'(1) << edge_dst);

    work_waddr = p_addr;
    work_we    = 1'b0;
    work_wdata = {1'b0, task_rd.preds};
    case (state)
      ST_INIT: work_we = p_valid;
      ST_DEC: begin
        work_we    = p_valid && row[p_addr];
        work_wdata = work_rdata - 7'd1;
      end
      default: work_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cycle_time   <= 16'hFFFF;
      task_count   <= 7'd64;
      row_valid    <= '0;
      res_valid    <= 1'b0;
      p_valid      <= 1'b0;
      cnt          <= '0;
      n_tasks      <= CW'(MAX_TASKS);
      assigned     <= '0;
      free_time    <= '0;
      cur_station  <= 7'd1;
      total        <= '0;
      station_used <= 1'b0;
      found        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_CYCLE_TIME: cycle_time <= cfg_data;
          CFG_TASK_COUNT: task_count <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (res_load) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;

      // shared sweep counter for copy, scan and decrement passes
      if (state == ST_INIT || state == ST_SCAN || state == ST_DEC) begin
        p_valid <= issue;
        p_addr  <= cnt[IW-1:0];
        if (issue) cnt <= cnt + 1'b1;
        else if (!p_valid) cnt <= '0;
      end else begin
        p_valid <= 1'b0;
        cnt     <= '0;
      end

      if (state == ST_SCAN && cand && (!found || task_rd.priority_val > best_pri)) begin
        found    <= 1'b1;
        best     <= p_addr;
        best_pri <= task_rd.priority_val;
        best_dur <= task_rd.duration;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            edge_src <= IW'(task_id - 7'd1);
            edge_dst <= IW'(successor_id - 7'd1);
            if (action == ACT_RUN) begin
              if (task_count == 7'd0) n_tasks <= CW'(1);
              else if (task_count > MAX7) n_tasks <= CW'(MAX_TASKS);
              else n_tasks <= CW'(task_count);
              assigned     <= '0;
              free_time    <= cycle_time;
              cur_station  <= 7'd1;
              total        <= '0;
              station_used <= 1'b0;
              found        <= 1'b0;
            end
          end
        end
        ST_EDGE: row_valid[edge_src] <= 1'b1;
        ST_PICK: begin
          if (found) begin
            if (out_free) begin
              task_id_res    <= 7'(best) + 7'd1;
              station        <= cur_station;
              last           <= ((total + 1'b1) == n_tasks);
              status         <= 1'b0;
              assigned[best] <= 1'b1;
              free_time      <= free_time - best_dur;
              total          <= total + 1'b1;
              station_used   <= 1'b1;
              found          <= 1'b0;
            end
          end else if (!station_used) begin
            if (out_free) begin
              // nothing fits an empty station: the run is stuck
              task_id_res <= 7'd0;
              station     <= cur_station;
              last        <= 1'b1;
              status      <= 1'b1;
            end
          end else begin
            cur_station  <= cur_station + 7'd1;
            free_time    <= cycle_time;
            station_used <= 1'b0;
          end
        end
        ST_ROW: row <= row_valid[best] ? succ_rdata : '0;
        default: ;
      endcase
    end
  end

endmodule

### test/line_balance_greedy_assigner_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for line_balance_greedy_assigner_core
// depends on lbga_pkg and the assigner rtl; predicts every placement internally

module line_balance_greedy_assigner_core_test;
  import lbga_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int NTASK = 64;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [6:0] task_no;
    logic [6:0] station_no;
    logic       final_flag;
    logic       stuck_flag;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  action = '0;
  logic [6:0]  task_id = '0;
  logic [15:0] duration = '0;
  logic [5:0]  pending_preds = '0;
  logic [23:0] priority_req = '0;
  logic [6:0]  successor_id = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [6:0]  task_id_res;
  logic [6:0]  station;
  logic        last;
  logic        status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  line_balance_greedy_assigner_core u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .action(action), .task_id(task_id), .duration(duration),
    .pending_preds(pending_preds), .priority_req(priority_req),
    .successor_id(successor_id),
    .res_valid(res_valid), .res_ready(res_ready),
    .task_id_res(task_id_res), .station(station), .last(last), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block state
  logic [15:0] cycle_cap = 16'hFFFF;
  logic [6:0]  task_total = 7'd64;
  logic [15:0] dur_mem [NTASK];
  logic [23:0] pri_mem [NTASK];
  logic [5:0]  preds_mem [NTASK];
  logic [63:0] succ_mem [NTASK];

  placement_t placements_due[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  function automatic int active_tasks();
    if (task_total == 0) return 1;
    if (task_total > NTASK) return NTASK;
    return task_total;
  endfunction

  function automatic void predict_run();
    int work [NTASK];
    logic [63:0] placed;
    int free_t, stn, total, n, best;
    bit found, used;
    logic [23:0] best_pri;
    placement_t p;
    n = active_tasks();
    for (int i = 0; i < NTASK; i++) work[i] = preds_mem[i];
    placed = '0;
    free_t = cycle_cap;
    stn = 1;
    total = 0;
    used = 0;
    while (total < n) begin
      found = 0;
      best = 0;
      best_pri = '0;
      for (int i = 0; i < n; i++) begin
        if (!placed[i] && work[i] == 0 && dur_mem[i] <= free_t) begin
          if (!found || pri_mem[i] > best_pri) begin
            found = 1;
            best = i;
            best_pri = pri_mem[i];
          end
        end
      end
      if (found) begin
        placed[best] = 1'b1;
        free_t -= dur_mem[best];
        for (int j = 0; j < NTASK; j++) if (succ_mem[best][j]) work[j]--;
        total++;
        used = 1;
        p.task_no = 7'(best + 1);
        p.station_no = 7'(stn);
        p.final_flag = (total == n);
        p.stuck_flag = 1'b0;
        placements_due.push_back(p);
      end else if (!used) begin
        p.task_no = '0;
        p.station_no = 7'(stn);
        p.final_flag = 1'b1;
        p.stuck_flag = 1'b1;
        placements_due.push_back(p);
        break;
      end else begin
        stn = (stn + 1) & 7'h7F;
        free_t = cycle_cap;
        used = 0;
      end
    end
  endfunction

  function automatic void apply_item(logic [1:0] act, logic [6:0] tid, logic [15:0] dur,
                                     logic [5:0] preds, logic [23:0] pri, logic [6:0] sid);
    if (act == ACT_LOAD && tid >= 1 && tid <= NTASK) begin
      dur_mem[tid-1] = dur;
      preds_mem[tid-1] = preds;
      pri_mem[tid-1] = pri;
    end else if (act == ACT_EDGE && tid >= 1 && tid <= NTASK && sid >= 1 && sid <= NTASK) begin
      succ_mem[tid-1][sid-1] = 1'b1;
    end else if (act == ACT_RUN) begin
      predict_run();
    end
  endfunction

  // returns at the edge where the transaction is taken; valid stays high
  task automatic send_item(logic [1:0] act, logic [6:0] tid, logic [15:0] dur,
                           logic [5:0] preds, logic [23:0] pri, logic [6:0] sid);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    task_id <= tid;
    duration <= dur;
    pending_preds <= preds;
    priority_req <= pri;
    successor_id <= sid;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
    apply_item(act, tid, dur, preds, pri, sid);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic load_task(int tid, logic [15:0] dur, logic [5:0] preds, logic [23:0] pri);
    send_item(ACT_LOAD, 7'(tid), dur, preds, pri, 7'($urandom_range(0, 127)));
  endtask

  task automatic add_edge(int src, int dst);
    send_item(ACT_EDGE, 7'(src), 16'($urandom), 6'($urandom), 24'($urandom), 7'(dst));
  endtask

  task automatic start_run();
    send_item(ACT_RUN, 7'($urandom), 16'($urandom), 6'($urandom), 24'($urandom),
              7'($urandom));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CYCLE_TIME) cycle_cap = value;
    else task_total = value[6:0];
  endtask

  // predecessor count of each task from the stored edges among active tasks
  function automatic logic [5:0] count_preds(int j, int n);
    int c;
    c = 0;
    for (int i = 0; i < n; i++) if (succ_mem[i][j]) c++;
    return 6'(c);
  endfunction

  always @(posedge clk) res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(negedge clk) begin
    placement_t e;
    if (res_valid && res_ready) begin
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: task %0d station %0d last %0d status %0d",
                   task_id_res, station, last, status);
      end else begin
        e = placements_due.pop_front();
        if (e.task_no !== task_id_res || e.station_no !== station ||
            e.final_flag !== last || e.stuck_flag !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp task %0d station %0d last %0d status %0d, got %0d %0d %0d %0d",
                     e.task_no, e.station_no, e.final_flag, e.stuck_flag,
                     task_id_res, station, last, status);
        end
      end
    end
    if (rst || (item_valid && item_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed_cases();
    cfg_write(CFG_CYCLE_TIME, 16'd10);
    cfg_write(CFG_TASK_COUNT, 16'd4);
    load_task(1, 16'd0, 6'd0, 24'hFFFFFF);
    load_task(2, 16'd10, 6'd1, 24'd1);
    load_task(3, 16'd5, 6'd1, 24'd0);
    load_task(4, 16'd5, 6'd0, 24'd0);
    add_edge(1, 2);
    add_edge(1, 3);
    add_edge(1, 3);
    // ignored: bad task numbers and the unused action
    send_item(ACT_LOAD, 7'd0, 16'hFFFF, 6'h3F, 24'hFFFFFF, 7'd1);
    send_item(ACT_LOAD, 7'd100, 16'hFFFF, 6'h3F, 24'hFFFFFF, 7'd1);
    send_item(ACT_EDGE, 7'd2, 16'd0, 6'd0, 24'd0, 7'd127);
    send_item(ACT_EDGE, 7'd0, 16'd0, 6'd0, 24'd0, 7'd64);
    send_item(ACT_UNUSED, 7'd1, 16'd0, 6'd0, 24'd0, 7'd1);
    start_run();
    start_run();
    // task longer than the cycle time
    load_task(2, 16'd11, 6'd1, 24'd1);
    start_run();
    // count decremented below zero stays blocked
    load_task(2, 16'd3, 6'd0, 24'd7);
    start_run();
    wait_idle();
    cfg_write(CFG_TASK_COUNT, 16'd0);
    cfg_write(CFG_CYCLE_TIME, 16'd1);
    load_task(1, 16'd1, 6'd0, 24'd5);
    start_run();
    wait_idle();
  endtask

  task automatic test_full_size();
    int a, b;
    cfg_write(CFG_TASK_COUNT, 16'd100);
    cfg_write(CFG_CYCLE_TIME, 16'hFFFF);
    for (int k = 0; k < 40; k++) begin
      a = $urandom_range(1, 63);
      b = $urandom_range(a + 1, 64);
      add_edge(a, b);
    end
    for (int t = 1; t <= NTASK; t++)
      load_task(t, 16'($urandom_range(0, 30000)), count_preds(t - 1, NTASK), 24'($urandom));
    start_run();
    // close a cycle between the two highest tasks
    add_edge(63, 64);
    add_edge(64, 63);
    load_task(63, 16'd100, count_preds(62, NTASK), 24'd3);
    load_task(64, 16'd100, count_preds(63, NTASK), 24'd3);
    start_run();
    wait_idle();
  endtask

  task automatic build_instance();
    int n, a, b, t;
    logic [15:0] dur;
    logic [5:0] preds;
    if ($urandom_range(0, 2) == 0) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: cfg_write(CFG_CYCLE_TIME, 16'hFFFF);
        1: cfg_write(CFG_CYCLE_TIME, 16'd1);
        default: cfg_write(CFG_CYCLE_TIME, 16'($urandom_range(2, 200)));
      endcase
      cfg_write(CFG_TASK_COUNT, 16'($urandom_range(1, 12)));
    end
    n = active_tasks();
    if (n > 1) begin
      repeat ($urandom_range(0, n)) begin
        a = $urandom_range(1, n - 1);
        b = $urandom_range(a + 1, n);
        add_edge(a, b);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) send_item(ACT_UNUSED, 7'($urandom), 16'($urandom),
                                          6'($urandom), 24'($urandom), 7'($urandom));
      else send_item(ACT_LOAD, 7'($urandom_range(65, 127)), 16'($urandom), 6'($urandom),
                     24'($urandom), 7'($urandom));
    end
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 1)) dur = 16'($urandom_range(0, cycle_cap));
      else dur = 16'($urandom_range(0, cycle_cap >> 2));
      preds = count_preds(j, n);
      load_task(j + 1, dur, preds,
                $urandom_range(0, 1) ? 24'($urandom_range(0, 3)) : 24'($urandom));
    end
    // occasional broken instance
    if ($urandom_range(0, 6) == 0) begin
      t = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) || cycle_cap == 16'hFFFF)
        load_task(t + 1, dur_mem[t], 6'(count_preds(t, n) + $urandom_range(1, 3)), pri_mem[t]);
      else
        load_task(t + 1, 16'(cycle_cap + 1), count_preds(t, n), pri_mem[t]);
    end
    start_run();
    if ($urandom_range(0, 4) == 0) start_run();
  endtask

  task automatic test_random_flow(int idle_pct, int stall_pct, int count);
    int stop_at;
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + count;
    while (items_sent < stop_at) build_instance();
  endtask

  initial begin
    for (int i = 0; i < NTASK; i++) succ_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_full_size();
    test_random_flow(0, 0, 65);
    test_random_flow(75, 0, 65);
    test_random_flow(0, 75, 65);
    test_random_flow(38, 38, 65);
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && placements_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lbga_pkg.sv
rtl/lbga_ram.sv
rtl/line_balance_greedy_assigner_core.sv
test/line_balance_greedy_assigner_core_test.sv
